// ===== rtl/core/rxs_pkg.sv =====
package rxs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int TAG_W  = 6;
  localparam int YEAR_W = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = YEAR_W;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEARS      = 1'd1;

  localparam logic [YEAR_W-1:0] REFERENCE_YEAR_RST = 12'd2025;
  localparam logic [YEAR_W-1:0] MIN_YEARS_RST      = 12'd20;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [YEAR_W-1:0] birth;
    logic [YEAR_W-1:0] join_yr;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller -> datapath
  typedef struct packed {
    logic              wr_en;
    logic              wr_from_in;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_cur;
    logic              swap;
    logic              emit;
    logic              emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lt;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/rxs_in_if.sv =====
interface rxs_in_if;
  logic                         valid;
  logic                         ready;
  logic [rxs_pkg::TAG_W-1:0]    record_tag;
  logic [rxs_pkg::YEAR_W-1:0]   birth_year;
  logic [rxs_pkg::YEAR_W-1:0]   join_year;
  logic                         last_record;

  modport source (output valid, record_tag, birth_year, join_year, last_record,
                  input ready);
  modport sink (input valid, record_tag, birth_year, join_year, last_record,
                output ready);
endinterface

// ===== rtl/core/rxs_out_if.sv =====
interface rxs_out_if;
  logic                         valid;
  logic                         ready;
  logic [rxs_pkg::TAG_W-1:0]    out_tag;
  logic [rxs_pkg::YEAR_W-1:0]   out_birth_year;
  logic [rxs_pkg::YEAR_W-1:0]   out_join_year;
  logic                         long_member;
  logic                         last_out;

  modport source (output valid, out_tag, out_birth_year, out_join_year, long_member,
                  last_out, input ready);
  modport sink (input valid, out_tag, out_birth_year, out_join_year, long_member,
                last_out, output ready);
endinterface

// ===== rtl/core/rxs_cfg_if.sv =====
interface rxs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rxs_pkg::CFG_IDX_W-1:0]    index;
  logic [rxs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rxs_ram.sv =====
module rxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/rxs_datapath.sv =====
module rxs_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rxs_pkg::rec_t    in_rec,
  input  rxs_pkg::cmd_t    cmd,
  output rxs_pkg::sts_t    sts,
  rxs_cfg_if.sink          cfg_ch,
  rxs_out_if.source        out_ch
);

  rxs_pkg::rec_t                 rd_rec;
  rxs_pkg::rec_t                 wr_rec;
  rxs_pkg::rec_t                 cur_r, cur_nxt;
  rxs_pkg::rec_t                 out_rec_r, out_rec_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_long_r, out_long_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [rxs_pkg::YEAR_W-1:0]    ref_year_r, ref_year_nxt;
  logic [rxs_pkg::YEAR_W-1:0]    min_years_r, min_years_nxt;
  logic signed [rxs_pkg::YEAR_W:0] diff;
  logic                          long_flag;

  assign wr_rec = cmd.wr_from_in ? in_rec : cur_r;

  rxs_ram #(
    .WIDTH (rxs_pkg::REC_W),
    .DEPTH (rxs_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (wr_rec),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_rec)
  );

  // duration is signed: a join year after the reference year never flags
  assign diff = $signed({1'b0, ref_year_r}) - $signed({1'b0, cur_r.join_yr});
  assign long_flag = (diff >= $signed({1'b0, min_years_r}));

  assign sts.lt       = (rd_rec.join_yr < cur_r.join_yr);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cur_nxt       = cur_r;
    out_rec_nxt   = out_rec_r;
    out_long_nxt  = out_long_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    ref_year_nxt  = ref_year_r;
    min_years_nxt = min_years_r;

    if (cmd.ld_cur || cmd.swap) begin
      cur_nxt = rd_rec;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = cur_r;
      out_long_nxt  = long_flag;
      out_last_nxt  = cmd.emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rxs_pkg::REG_REFERENCE_YEAR: ref_year_nxt  = cfg_ch.data;
        rxs_pkg::REG_MIN_YEARS:      min_years_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ref_year_r  <= rxs_pkg::REFERENCE_YEAR_RST;
      min_years_r <= rxs_pkg::MIN_YEARS_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      ref_year_r  <= ref_year_nxt;
      min_years_r <= min_years_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_rec_r  <= out_rec_nxt;
    out_long_r <= out_long_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_tag        = out_rec_r.tag;
  assign out_ch.out_birth_year = out_rec_r.birth;
  assign out_ch.out_join_year  = out_rec_r.join_yr;
  assign out_ch.long_member    = out_long_r;
  assign out_ch.last_out       = out_last_r;

endmodule

// ===== rtl/core/rxs_ctrl.sv =====
module rxs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  rxs_pkg::sts_t sts,
  output rxs_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RDI  = 6'b000010,
    S_LDI  = 6'b000100,
    S_RDJ  = 6'b001000,
    S_CMP  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [rxs_pkg::ADDR_W-1:0]  i_r, i_nxt;
  logic [rxs_pkg::CNT_W-1:0]   j_r, j_nxt;
  logic [rxs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rxs_pkg::CNT_W-1:0]   i_ext;
  logic [rxs_pkg::CNT_W-1:0]   j_inc;

  assign i_ext = {1'b0, i_r};
  assign j_inc = j_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a record arriving at a full store is dropped
          if (cnt_r < rxs_pkg::CNT_W'(rxs_pkg::MAX_RECORDS)) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_from_in = 1'b1;
            cmd.wr_addr    = cnt_r[rxs_pkg::ADDR_W-1:0];
            cnt_nxt        = cnt_r + 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        cmd.rd_addr = i_r;
        state_nxt   = S_LDI;
      end
      S_LDI: begin
        cmd.ld_cur = 1'b1;
        j_nxt      = i_ext + 1'b1;
        state_nxt  = ((i_ext + 1'b1) < cnt_r) ? S_RDJ : S_EMIT;
      end
      S_RDJ: begin
        cmd.rd_addr = j_r[rxs_pkg::ADDR_W-1:0];
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        // held record goes to slot j, the smaller one becomes the candidate
        if (sts.lt) begin
          cmd.swap    = 1'b1;
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = j_r[rxs_pkg::ADDR_W-1:0];
        end
        j_nxt     = j_inc;
        state_nxt = (j_inc < cnt_r) ? S_RDJ : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = ((i_ext + 1'b1) == cnt_r);
          if (cmd.emit_last) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RDI;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/record_exchange_sort_by_year.sv =====
// Load: one record per cycle, no result until the last record of a set.
// Sort and output for n records: outer pass i reads record i as the candidate,
// compares it with records i+1 to n-1 on the one-read, one-write record store, then hands record i
// to the output register once that register is free.
// Reset (rst_n low, synchronous): empty store, loading, registers 2025 and 20;
// store contents are not cleared.
module record_exchange_sort_by_year (
  input  logic      clk,
  input  logic      rst_n,
  rxs_in_if.sink    in_ch,
  rxs_out_if.source out_ch,
  rxs_cfg_if.sink   cfg_ch
);

  rxs_pkg::rec_t in_rec;
  rxs_pkg::cmd_t cmd;
  rxs_pkg::sts_t sts;
  logic          in_ready;

  assign in_rec.tag     = in_ch.record_tag;
  assign in_rec.birth   = in_ch.birth_year;
  assign in_rec.join_yr = in_ch.join_year;
  assign in_ch.ready    = in_ready;

  rxs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_record),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rxs_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rec (in_rec),
    .cmd    (cmd),
    .sts    (sts),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_from_in) |-> (in_ch.valid && in_ch.ready))
    else $error("store loaded without an input transaction");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwritten before it was taken");

  a_swap_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |-> (sts.lt && cmd.wr_en && !cmd.wr_from_in))
    else $error("swap without a smaller key or without write-back");

  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> in_ch.ready)
    else $error("not loading after the final result");

endmodule
